/* design/hsl_to_rgb_converter_defines.svh */
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HSL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl_to_rgb_converter: check failed");

// next-cycle implication, checked outside reset
`define HSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl_to_rgb_converter: check failed");

`endif

/* design/hsl_pkg.sv */
package hsl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int HUE_W      = 16;
  localparam int SAT_W      = 17;
  localparam int FIX_W      = FRAC_BITS + 1;
  localparam int WIDE_W     = FRAC_BITS + 2;
  localparam int T6_W       = FRAC_BITS + 3;
  localparam int PROD_W     = 2 * FIX_W;
  localparam int BYTE_W     = 8;
  localparam int ARGB_W     = 32;
  localparam int NUM_STAGES = 5;

  localparam logic [FIX_W-1:0]  ONE      = FIX_W'(1) << FRAC_BITS;
  localparam logic [WIDE_W-1:0] ONE_W    = WIDE_W'(1) << FRAC_BITS;
  localparam logic [T6_W-1:0]   ONE_T6   = T6_W'(1) << FRAC_BITS;
  localparam logic [T6_W-1:0]   FOUR_ONE = T6_W'(4) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((2 * (1 << FRAC_BITS) + 3) / 6);

  localparam logic [FRAC_BITS-1:0] OFS_RED   = THIRD;
  localparam logic [FRAC_BITS-1:0] OFS_GREEN = '0;
  localparam logic [FRAC_BITS-1:0] OFS_BLUE  = FRAC_BITS'((1 << FRAC_BITS) - int'(THIRD));

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [BYTE_W+1:0] BYTE_MAX     = 10'd255;

  typedef logic [FIX_W-1:0]     fix_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  typedef enum logic [1:0] {
    RAMP_UP   = 2'd0,
    RAMP_TOP  = 2'd1,
    RAMP_DOWN = 2'd2,
    RAMP_LOW  = 2'd3
  } ramp_mode_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

endpackage

/* design/hsl_in_if.sv */
interface hsl_in_if;
  import hsl_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [SAT_W-1:0] lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

/* design/hsl_out_if.sv */
interface hsl_out_if;
  import hsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [ARGB_W-1:0] packed_argb;

  modport source (output valid, red, green, blue, packed_argb, input ready);
  modport sink   (input valid, red, green, blue, packed_argb, output ready);
endinterface

/* design/hsl_to_rgb_converter.sv */
// HSL to RGB colour converter.
// hsl: input channel, one word per pixel carrying hue (fraction of a turn),
//      saturation and lightness (Q1.16, values above one are clamped).
// rgb: output channel, one word per pixel carrying red, green and blue bytes
//      and the opaque ARGB word built from them.
// Both channels use valid/ready; a word moves when both are high.
// The five register stages are clamp and l*s product, q/p, hue ramp
//   select, ramp product and byte scaling.
// Throughput: one pixel per clock while rgb.ready is high.
// Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it loads, so a stalled receiver holds the result in the
//   output register while earlier stages keep filling any empty slots;
//   hsl.ready falls only once all five stages are full.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
module hsl_to_rgb_converter (
  input logic      clk,
  input logic      rst,
  hsl_in_if.sink   hsl,
  hsl_out_if.source rgb
);
  import hsl_pkg::*;

  `include "hsl_to_rgb_converter_defines.svh"

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] adv;
  pipe_ctrl_t            ctrl;
  frac_t                 h2;
  fix_t                  p2;
  fix_t                  q2;
  fix_t                  d2;
  byte_t                 red;
  byte_t                 green;
  byte_t                 blue;

  always_comb begin
    adv[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || rgb.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !stage_valid[k] || adv[k+1];
    end
    ctrl.load = adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[0]) begin
        stage_valid[0] <= hsl.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign hsl.ready = adv[0];

  hsl_front u_front (
    .clk        (clk),
    .ctrl       (ctrl),
    .hue        (hsl.hue),
    .saturation (hsl.saturation),
    .lightness  (hsl.lightness),
    .h          (h2),
    .p          (p2),
    .q          (q2),
    .d          (d2)
  );

  hsl_chan u_red (
    .clk    (clk),
    .ctrl   (ctrl),
    .offset (OFS_RED),
    .h      (h2),
    .p      (p2),
    .q      (q2),
    .d      (d2),
    .level  (red)
  );

  hsl_chan u_green (
    .clk    (clk),
    .ctrl   (ctrl),
    .offset (OFS_GREEN),
    .h      (h2),
    .p      (p2),
    .q      (q2),
    .d      (d2),
    .level  (green)
  );

  hsl_chan u_blue (
    .clk    (clk),
    .ctrl   (ctrl),
    .offset (OFS_BLUE),
    .h      (h2),
    .p      (p2),
    .q      (q2),
    .d      (d2),
    .level  (blue)
  );

  assign rgb.valid       = stage_valid[NUM_STAGES-1];
  assign rgb.red         = red;
  assign rgb.green       = green;
  assign rgb.blue        = blue;
  assign rgb.packed_argb = {ALPHA_OPAQUE, red, green, blue};

  `HSL_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), stage_valid == '0)
  `HSL_ASSERT_NEXT(a_middle_word_held, clk, rst, stage_valid[2] && !adv[3], stage_valid[2])
  `HSL_ASSERT_NOW(a_ready_when_empty, clk, rst, !stage_valid[0], hsl.ready)

endmodule

/* design/hsl_front.sv */
module hsl_front (
  input  logic                               clk,
  input  hsl_pkg::pipe_ctrl_t                ctrl,
  input  logic [hsl_pkg::HUE_W-1:0]          hue,
  input  logic [hsl_pkg::SAT_W-1:0]          saturation,
  input  logic [hsl_pkg::SAT_W-1:0]          lightness,
  output hsl_pkg::frac_t                     h,
  output hsl_pkg::fix_t                      p,
  output hsl_pkg::fix_t                      q,
  output hsl_pkg::fix_t                      d
);
  import hsl_pkg::*;

  fix_t               s_clamp;
  fix_t               l_clamp;
  logic [PROD_W-1:0]  ls_prod;
  frac_t              h1;
  fix_t               s1;
  fix_t               l1;
  fix_t               m1;
  logic [WIDE_W-1:0]  two_l;
  logic [WIDE_W-1:0]  q_lo;
  logic [WIDE_W-1:0]  q_hi;
  logic [WIDE_W-1:0]  q_wide;
  fix_t               q_next;
  fix_t               p_next;
  fix_t               d_next;

  always_comb begin
    s_clamp = (saturation > SAT_W'(ONE)) ? ONE : FIX_W'(saturation);
    l_clamp = (lightness > SAT_W'(ONE)) ? ONE : FIX_W'(lightness);
    ls_prod = PROD_W'(s_clamp) * PROD_W'(l_clamp);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      h1 <= hue[FRAC_BITS-1:0];
      s1 <= s_clamp;
      l1 <= l_clamp;
      m1 <= ls_prod[FRAC_BITS +: FIX_W];
    end
  end

  always_comb begin
    two_l  = {l1, 1'b0};
    q_lo   = WIDE_W'(l1) + WIDE_W'(m1);
    q_hi   = WIDE_W'(l1) + WIDE_W'(s1) - WIDE_W'(m1);
    q_wide = (two_l < ONE_W) ? q_lo : q_hi;
    q_next = q_wide[FIX_W-1:0];
    p_next = (two_l > q_wide) ? FIX_W'(two_l - q_wide) : '0;
    d_next = (q_next > p_next) ? q_next - p_next : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      h <= h1;
      q <= q_next;
      p <= p_next;
      d <= d_next;
    end
  end

endmodule

/* design/hsl_chan.sv */
module hsl_chan (
  input  logic                clk,
  input  hsl_pkg::pipe_ctrl_t ctrl,
  input  hsl_pkg::frac_t      offset,
  input  hsl_pkg::frac_t      h,
  input  hsl_pkg::fix_t       p,
  input  hsl_pkg::fix_t       q,
  input  hsl_pkg::fix_t       d,
  output hsl_pkg::byte_t      level
);
  import hsl_pkg::*;

  frac_t               t;
  logic [T6_W-1:0]     t6;
  logic [WIDE_W-1:0]   t3;
  ramp_mode_t          mode_next;
  fix_t                f_next;
  ramp_mode_t          mode3;
  fix_t                f3;
  fix_t                p3;
  fix_t                q3;
  fix_t                d3;
  ramp_mode_t          mode4;
  logic [PROD_W-1:0]   prod4;
  fix_t                p4;
  fix_t                q4;
  logic [WIDE_W-1:0]   v;
  logic [WIDE_W+7:0]   scaled;
  logic [BYTE_W+1:0]   top;
  byte_t               level_next;

  always_comb begin
    t  = h + offset;
    t3 = {2'b00, t} + {1'b0, t, 1'b0};
    t6 = {t3, 1'b0};
    if (t6 < ONE_T6) begin
      mode_next = RAMP_UP;
      f_next    = t6[FIX_W-1:0];
    end else if (!t[FRAC_BITS-1]) begin
      mode_next = RAMP_TOP;
      f_next    = '0;
    end else if (t3 < {ONE_W[WIDE_W-2:0], 1'b0}) begin
      mode_next = RAMP_DOWN;
      f_next    = FIX_W'(FOUR_ONE - t6);
    end else begin
      mode_next = RAMP_LOW;
      f_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      mode3 <= mode_next;
      f3    <= f_next;
      p3    <= p;
      q3    <= q;
      d3    <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      mode4 <= mode3;
      prod4 <= PROD_W'(d3) * PROD_W'(f3);
      p4    <= p3;
      q4    <= q3;
    end
  end

  always_comb begin
    case (mode4)
      RAMP_UP, RAMP_DOWN: v = WIDE_W'(p4) + WIDE_W'(prod4[FRAC_BITS +: FIX_W]);
      RAMP_TOP:           v = WIDE_W'(q4);
      RAMP_LOW:           v = WIDE_W'(p4);
      default:            v = WIDE_W'(p4);
    endcase
    scaled     = {v, 8'h00} - (WIDE_W + 8)'(v);
    top        = scaled[FRAC_BITS +: BYTE_W + 2];
    level_next = (top > BYTE_MAX) ? ALPHA_OPAQUE : top[BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      level <= level_next;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hsl_pkg::*;

  localparam longint unsigned UNIT       = 64'd1 << FRAC_BITS;
  localparam longint unsigned HUE_WRAP   = UNIT - 64'd1;
  localparam longint unsigned THIRD_TURN = (64'd2 * UNIT + 64'd3) / 64'd6;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 150;
  localparam int ROW_COUNT    = 22;

  typedef struct packed {
    byte_t       red;
    byte_t       green;
    byte_t       blue;
    logic [31:0] argb;
  } rgb_word_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] light;
    logic             known;
    byte_t            red;
    byte_t            green;
    byte_t            blue;
  } hsl_row_t;

  hsl_row_t rows [ROW_COUNT] = '{
    '{16'h0000, 17'h00000, 17'h00000, 1'b1, 8'h00, 8'h00, 8'h00},
    '{16'h0000, 17'h00000, 17'h10000, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{16'h1234, 17'h00000, 17'h08000, 1'b1, 8'h7F, 8'h7F, 8'h7F},
    '{16'hBEEF, 17'h00000, 17'h1FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{16'hFFFF, 17'h10000, 17'h00000, 1'b1, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 17'h10000, 17'h10000, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{16'h5555, 17'h1FFFF, 17'h1FFFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{16'h0000, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h5555, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hAAAB, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h2AAA, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h2AAB, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h8000, 17'h10000, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hD555, 17'h1FFFF, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hFFFF, 17'h10000, 17'h07FFF, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h0001, 17'h00001, 17'h08000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h4000, 17'h0FFFF, 17'h00001, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hC000, 17'h08000, 17'h0FFFF, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h6000, 17'h18000, 17'h04000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h9000, 17'h0AAAA, 17'h0C000, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'hE000, 17'h10000, 17'h0FFFF, 1'b0, 8'h00, 8'h00, 8'h00},
    '{16'h7FFF, 17'h05555, 17'h1A000, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  logic clk = 1'b0;
  logic rst;

  hsl_in_if  hsl ();
  hsl_out_if rgb ();

  hsl_to_rgb_converter DUT (
    .clk (clk),
    .rst (rst),
    .hsl (hsl),
    .rgb (rgb)
  );

  always #1 clk = ~clk;

  rgb_word_t   colour_queue [$];
  int unsigned mismatches  = 0;
  logic        tail        = 1'b0;
  int unsigned idle_odds   = 0;
  int unsigned stall_odds  = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_left  = 0;

  function automatic longint unsigned ramp_level(longint unsigned p, longint unsigned q,
                                                  longint unsigned t);
    longint unsigned d;
    longint unsigned t6;
    d  = q > p ? q - p : 64'd0;
    t6 = 64'd6 * t;
    if (t6 < UNIT) return p + ((d * t6) >> FRAC_BITS);
    if (64'd2 * t < UNIT) return q;
    if (64'd3 * t < 64'd2 * UNIT) return p + ((d * (64'd4 * UNIT - t6)) >> FRAC_BITS);
    return p;
  endfunction

  function automatic byte_t level_byte(longint unsigned v);
    longint unsigned b;
    b = (v * 64'd255) >> FRAC_BITS;
    return b > 64'd255 ? 8'hFF : b[7:0];
  endfunction

  function automatic rgb_word_t hsl_colour(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                           logic [SAT_W-1:0] light);
    longint unsigned h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned q;
    longint unsigned p;
    rgb_word_t       w;
    h = 64'(hue) & HUE_WRAP;
    s = 64'(sat) > UNIT ? UNIT : 64'(sat);
    l = 64'(light) > UNIT ? UNIT : 64'(light);
    if (s == 0) begin
      w.red   = level_byte(l);
      w.green = w.red;
      w.blue  = w.red;
    end else begin
      if (64'd2 * l < UNIT) q = (l * (UNIT + s)) >> FRAC_BITS;
      else q = l + s - ((l * s) >> FRAC_BITS);
      p = 64'd2 * l > q ? 64'd2 * l - q : 64'd0;
      w.red   = level_byte(ramp_level(p, q, (h + THIRD_TURN) & HUE_WRAP));
      w.green = level_byte(ramp_level(p, q, h));
      w.blue  = level_byte(ramp_level(p, q, (h + UNIT - THIRD_TURN) & HUE_WRAP));
    end
    w.argb = {ALPHA_OPAQUE, w.red, w.green, w.blue};
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_pixel(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                            logic [SAT_W-1:0] light, rgb_word_t want);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      gap = $urandom_range(1, 9);
      hsl.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsl.valid      <= 1'b1;
    hsl.hue        <= hue;
    hsl.saturation <= sat;
    hsl.lightness  <= light;
    do @(posedge clk); while (!hsl.ready);
    colour_queue.push_back(want);
  endtask

  always @(posedge clk) begin
    rgb_word_t want;
    if (rst) begin
      rgb.ready <= 1'b0;
    end else begin
      if (rgb.valid && rgb.ready) begin
        if (colour_queue.size() == 0) begin
          $display("%0t: no word expected, got argb %h", $time, rgb.packed_argb);
          mismatches++;
        end else begin
          want = colour_queue.pop_front();
          check_field("red", 32'(want.red), 32'(rgb.red));
          check_field("green", 32'(want.green), 32'(rgb.green));
          check_field("blue", 32'(want.blue), 32'(rgb.blue));
          check_field("packed_argb", want.argb, rgb.packed_argb);
        end
      end
      if (stall_phase == 0) begin
        stall_odds  = $urandom_range(0, 3);
        stall_phase = 64;
      end
      stall_phase--;
      if (stall_left != 0 && !tail) begin
        stall_left--;
        rgb.ready <= 1'b0;
      end else if (!tail && stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
        stall_left = $urandom_range(1, 9) - 1;
        rgb.ready <= 1'b0;
      end else begin
        rgb.ready <= 1'b1;
      end
    end
  end

  initial begin
    rgb_word_t        want;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] light;
    int unsigned      pick;
    rst            <= 1'b1;
    hsl.valid      <= 1'b0;
    hsl.hue        <= '0;
    hsl.saturation <= '0;
    hsl.lightness  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_odds = 2;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        want.red   = rows[i].red;
        want.green = rows[i].green;
        want.blue  = rows[i].blue;
        want.argb  = {ALPHA_OPAQUE, rows[i].red, rows[i].green, rows[i].blue};
      end else begin
        want = hsl_colour(rows[i].hue, rows[i].sat, rows[i].light);
      end
      send_pixel(rows[i].hue, rows[i].sat, rows[i].light, want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idle_odds = $urandom_range(0, 3);
      if (n >= RANDOM_ITEMS - TAIL_ITEMS) begin
        idle_odds = 0;
        tail <= 1'b1;
      end
      hue  = HUE_W'($urandom());
      pick = $urandom_range(0, 15);
      case (pick)
        0: begin
          sat = '0;
        end
        1: begin
          sat = SAT_W'($urandom_range(0, 131071));
        end
        2: begin
          sat = ONE;
        end
        default: begin
          sat = SAT_W'($urandom_range(0, 65536));
        end
      endcase
      pick = $urandom_range(0, 15);
      case (pick)
        0: begin
          light = SAT_W'($urandom_range(0, 131071));
        end
        1: begin
          light = SAT_W'($urandom_range(32767, 32768));
        end
        2: begin
          light = $urandom_range(0, 1) ? ONE : '0;
        end
        default: begin
          light = SAT_W'($urandom_range(0, 65536));
        end
      endcase
      send_pixel(hue, sat, light, hsl_colour(hue, sat, light));
    end
    hsl.valid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
